>>> hdl/ntps_pkg.sv
`timescale 1ns / 1ps

package ntps_pkg;

    localparam int MAC_W  = 48;
    localparam int RSSI_W = 9;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;
    localparam int CMD_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SELECT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    localparam logic [RSSI_W-1:0] MARGIN_RST = 9'd20;
    localparam logic [CNT_W-1:0]  HOP_MAX    = 8'd255;

    typedef struct packed {
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [CNT_W-1:0]         count;
    } t_entry;

endpackage

>>> hdl/ntps_if.sv
`timescale 1ns / 1ps

interface ntps_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               cmd;
    logic [47:0]              mac;
    logic signed [8:0]        rssi;
    logic [7:0]               count;

    modport source (output valid, cmd, mac, rssi, count, input ready);
    modport sink   (input valid, cmd, mac, rssi, count, output ready);
endinterface

interface ntps_out_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic                     found;
    logic [4:0]               entry_count;
    logic                     parent_valid;
    logic [47:0]              parent_mac;
    logic signed [8:0]        parent_rssi;
    logic [7:0]               hop;

    modport source (output valid, status, found, entry_count, parent_valid, parent_mac,
                    parent_rssi, hop, input ready);
    modport sink   (input valid, status, found, entry_count, parent_valid, parent_mac,
                    parent_rssi, hop, output ready);
endinterface

>>> hdl/neighbor_table_parent_select_top.sv
`timescale 1ns / 1ps

// Mesh neighbor table with parent selection. The table lives in a ring of
// DEPTH cells; every command rotates the ring once, one entry per cycle past
// the head cell, while the sequencer edits the entry written back into the
// tail (in-place update, append, or compaction on delete) and scans for the
// best parent. One item is in work at a time: the accept, DEPTH ring shifts,
// the registering of the result (held off while an earlier result still
// waits) and a return to idle for the next accept. The result register lets
// the next item be accepted while the previous result still waits.
// rssi_margin is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset sets it to 20 and empties the table; no clearing pass is needed.
module neighbor_table_parent_select_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntps_in_if.sink     i_in,
    ntps_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);

    // neighbor of the head cell: where the entry after the head sits
    localparam int NXT = (DEPTH > 1) ? 1 : 0;

    ntps_pkg::t_entry w_cell [DEPTH];
    ntps_pkg::t_entry w_tail;
    logic             w_shift;

    // ring of slots; cell 0 is the head seen by the sequencer,
    // the last cell takes the edited entry
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == DEPTH - 1) begin : g_tail
            ntps_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_next  (w_tail),
                .o_entry (w_cell[k])
            );
        end else begin : g_mid
            ntps_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_next  (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

    ntps_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_cell[0]),
        .i_next      (w_cell[NXT]),
        .o_tail      (w_tail),
        .o_shift     (w_shift)
    );

endmodule

>>> hdl/ntps_cell.sv
`timescale 1ns / 1ps

// One table slot; loads its upstream neighbor on every shift.
module ntps_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  ntps_pkg::t_entry i_next,
    output ntps_pkg::t_entry o_entry
);

    ntps_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/ntps_ctrl.sv
`timescale 1ns / 1ps

// Command sequencer: walks the ring once per item, edits the stream written
// back into the tail cell and builds the result.
module ntps_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ntps_in_if.sink                 i_in,
    ntps_out_if.source              o_out,
    input  logic                    i_cfg_we,
    input  logic [8:0]              i_cfg_wdata,
    input  ntps_pkg::t_entry        i_head,
    input  ntps_pkg::t_entry        i_next,
    output ntps_pkg::t_entry        o_tail,
    output logic                    o_shift
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                                r_state;
    logic [ntps_pkg::CMD_W-1:0]            r_cmd;
    logic [ntps_pkg::MAC_W-1:0]            r_mac;
    logic signed [ntps_pkg::RSSI_W-1:0]    r_rssi;
    logic [ntps_pkg::CNT_W-1:0]            r_cnt;
    logic [ntps_pkg::RSSI_W-1:0]           r_margin;
    logic [CW-1:0]                         r_count;
    logic [SW-1:0]                         r_step;
    logic                                  r_hit;
    ntps_pkg::t_entry                      r_best;

    logic                                  r_ovalid;
    logic [ntps_pkg::STAT_W-1:0]           r_status;
    logic                                  r_found;
    logic [ntps_pkg::ECNT_W-1:0]           r_ecnt;
    logic                                  r_pvalid;
    logic [ntps_pkg::MAC_W-1:0]            r_pmac;
    logic signed [ntps_pkg::RSSI_W-1:0]    r_prssi;
    logic [ntps_pkg::CNT_W-1:0]            r_hop;

    logic                                  in_range;
    logic                                  match;
    logic                                  n_hit;
    logic                                  take_best;
    logic                                  load_out;
    logic [CW-1:0]                         n_count;
    logic [ntps_pkg::STAT_W-1:0]           n_status;
    logic                                  n_found;
    logic                                  n_pvalid;
    logic [ntps_pkg::MAC_W-1:0]            n_pmac;
    logic signed [ntps_pkg::RSSI_W-1:0]    n_prssi;
    logic [ntps_pkg::CNT_W-1:0]            n_hop;

    // a strictly beats b
    function automatic logic beats(input ntps_pkg::t_entry a, input ntps_pkg::t_entry b,
                                   input logic [8:0] margin);
        logic signed [9:0] d;
        logic [9:0]        ad;
        logic              res;
        d   = 10'(a.rssi) - 10'(b.rssi);
        ad  = d[9] ? 10'(-d) : 10'(d);
        res = a.count < b.count;
        if (a.rssi != '0 && b.rssi != '0 && ad > {1'b0, margin}) begin
            res = a.rssi > b.rssi;
        end
        return res;
    endfunction

    assign o_shift  = (r_state == S_SCAN);
    assign in_range = CW'(r_step) < r_count;
    assign match    = in_range && (i_head.mac == r_mac);
    assign n_hit    = r_hit | match;
    assign take_best = in_range && (r_step == '0 || beats(i_head, r_best, r_margin));

    // stream written back into the tail: position r_step of the new table
    always_comb begin
        o_tail = i_head;
        case (r_cmd)
            ntps_pkg::CMD_UPDATE: begin
                if (match) begin
                    o_tail.rssi  = r_rssi;
                    o_tail.count = r_cnt;
                end else if (!r_hit && CW'(r_step) == r_count) begin
                    o_tail.mac   = r_mac;
                    o_tail.rssi  = r_rssi;
                    o_tail.count = r_cnt;
                end
            end
            ntps_pkg::CMD_DELETE: begin
                if (n_hit) begin
                    o_tail = i_next;
                end
            end
            default: begin
            end
        endcase
    end

    // result of the finished pass
    always_comb begin
        n_count  = r_count;
        n_status = ntps_pkg::STAT_OK;
        n_found  = 1'b0;
        n_pvalid = 1'b0;
        n_pmac   = '0;
        n_prssi  = '0;
        n_hop    = '0;
        case (r_cmd)
            ntps_pkg::CMD_UPDATE: begin
                if (r_hit) begin
                    n_found = 1'b1;
                end else if (r_count < FULL_CNT) begin
                    n_found = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    n_status = ntps_pkg::STAT_FULL;
                end
            end
            ntps_pkg::CMD_DELETE: begin
                if (r_hit) begin
                    n_found = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ntps_pkg::STAT_MISS;
                end
            end
            ntps_pkg::CMD_LOOKUP: begin
                if (r_hit) begin
                    n_found = 1'b1;
                end else begin
                    n_status = ntps_pkg::STAT_MISS;
                end
            end
            ntps_pkg::CMD_SELECT: begin
                if (r_count == '0) begin
                    n_hop = ntps_pkg::HOP_MAX;
                end else begin
                    n_pvalid = 1'b1;
                    n_pmac   = r_best.mac;
                    n_prssi  = r_best.rssi;
                    n_hop    = (r_best.count == ntps_pkg::HOP_MAX) ? ntps_pkg::HOP_MAX
                                                                   : r_best.count + 8'd1;
                end
            end
            ntps_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign load_out = (r_state == S_FIN) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
            r_margin <= ntps_pkg::MARGIN_RST;
        end else begin
            if (i_cfg_we) begin
                r_margin <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_SCAN;
                        r_step  <= '0;
                        r_hit   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_hit  <= n_hit;
                    r_step <= r_step + SW'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load_out) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd  <= i_in.cmd;
            r_mac  <= i_in.mac;
            r_rssi <= i_in.rssi;
            r_cnt  <= i_in.count;
        end
        if (r_state == S_SCAN && r_cmd == ntps_pkg::CMD_SELECT && take_best) begin
            r_best <= i_head;
        end
        if (load_out) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_ecnt   <= ntps_pkg::ECNT_W'(n_count);
            r_pvalid <= n_pvalid;
            r_pmac   <= n_pmac;
            r_prssi  <= n_prssi;
            r_hop    <= n_hop;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_status;
    assign o_out.found          = r_found;
    assign o_out.entry_count    = r_ecnt;
    assign o_out.parent_valid   = r_pvalid;
    assign o_out.parent_mac     = r_pmac;
    assign o_out.parent_rssi    = r_prssi;
    assign o_out.hop            = r_hop;

endmodule

>>> hdl/ntps_checker.sv
`timescale 1ns / 1ps

module ntps_checker #(
    parameter int DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic        i_found,
    input logic [4:0]  i_entry_count,
    input logic        i_parent_valid,
    input logic [47:0] i_parent_mac,
    input logic [7:0]  i_hop
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_entry_count) && $stable(i_parent_mac) && $stable(i_hop)))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_entry_count) <= DEPTH || DEPTH > 31))
        else $error("entry count above table depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ntps_pkg::STAT_FULL) |->
            (!i_found && 5'(DEPTH) == i_entry_count))
        else $error("full status with room left");

    a_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_parent_valid) |->
            (i_status == ntps_pkg::STAT_OK && !i_found && i_entry_count != 5'd0
             && i_hop != 8'd0))
        else $error("parent reported with inconsistent fields");

endmodule

bind neighbor_table_parent_select_top ntps_checker #(
    .DEPTH (DEPTH)
) u_ntps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_found        (o_out.found),
    .i_entry_count  (o_out.entry_count),
    .i_parent_valid (o_out.parent_valid),
    .i_parent_mac   (o_out.parent_mac),
    .i_hop          (o_out.hop)
);

>>> test/tb.sv
`timescale 1ns / 1ps

// Neighbor table testbench: a command queue feeds a falling-edge driver, and a
// shadow copy of the table predicts every result at the moment its command
// is accepted. A rising-edge monitor checks each returned item in order.
module tb;

    localparam int TBL_DEPTH = 16;
    localparam int POOL_SZ   = 22;     // a few more MACs than slots, so the table fills
    localparam int STALL_MAX = 4000;   // cycles with no handshake before giving up
    localparam int HOLD_LEN  = 200;    // long receiver hold-off

    // command codes with no function; the block ignores them
    localparam logic [ntps_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [ntps_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [ntps_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    typedef struct {
        logic [ntps_pkg::CMD_W-1:0]         cmd;
        logic [ntps_pkg::MAC_W-1:0]         mac;
        logic signed [ntps_pkg::RSSI_W-1:0] rssi;
        logic [ntps_pkg::CNT_W-1:0]         count;
        bit                                 drain_first;   // wait for every result first
    } t_cmd_item;

    typedef struct packed {
        logic [ntps_pkg::STAT_W-1:0]        status;
        logic                               found;
        logic [ntps_pkg::ECNT_W-1:0]        entry_count;
        logic                               parent_valid;
        logic [ntps_pkg::MAC_W-1:0]         parent_mac;
        logic signed [ntps_pkg::RSSI_W-1:0] parent_rssi;
        logic [ntps_pkg::CNT_W-1:0]         hop;
    } t_nbr_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    ntps_in_if  cmd_ch();
    ntps_out_if res_ch();

    neighbor_table_parent_select_top #(.DEPTH(TBL_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // shadow of the neighbor table
    logic [ntps_pkg::MAC_W-1:0]         nbr_mac   [TBL_DEPTH];
    logic signed [ntps_pkg::RSSI_W-1:0] nbr_rssi  [TBL_DEPTH];
    logic [ntps_pkg::CNT_W-1:0]         nbr_count [TBL_DEPTH];
    int                                 nbr_used;
    logic [8:0]                         margin_sh;

    t_cmd_item   pending_cmds[$];
    t_nbr_result due_results[$];
    logic [ntps_pkg::MAC_W-1:0] mac_pool[POOL_SZ];

    int  mismatches;
    int  idle_cycles;
    bit  cmd_taken;
    bit  no_idle;
    bit  hold_req;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Shadow table update; returns the result the block owes for this command.
    function automatic t_nbr_result table_apply(logic [ntps_pkg::CMD_W-1:0] c,
                                                logic [ntps_pkg::MAC_W-1:0] m,
                                                logic signed [ntps_pkg::RSSI_W-1:0] r,
                                                logic [ntps_pkg::CNT_W-1:0] k);
        t_nbr_result res;
        int hit;
        int best;
        int ra;
        int rb;
        int diff;
        bit wins;
        res = '0;
        hit = -1;
        for (int i = 0; i < nbr_used; i++)
            if (hit < 0 && nbr_mac[i] == m) hit = i;
        case (c)
            ntps_pkg::CMD_UPDATE: begin
                if (hit >= 0) begin
                    nbr_rssi[hit]  = r;
                    nbr_count[hit] = k;
                    res.found = 1'b1;
                end else if (nbr_used < TBL_DEPTH) begin
                    nbr_mac[nbr_used]   = m;
                    nbr_rssi[nbr_used]  = r;
                    nbr_count[nbr_used] = k;
                    nbr_used++;
                    res.found = 1'b1;
                end else begin
                    res.status = ntps_pkg::STAT_FULL;
                end
            end
            ntps_pkg::CMD_DELETE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < nbr_used; i++) begin
                        nbr_mac[i]   = nbr_mac[i+1];
                        nbr_rssi[i]  = nbr_rssi[i+1];
                        nbr_count[i] = nbr_count[i+1];
                    end
                    nbr_used--;
                    res.found = 1'b1;
                end else begin
                    res.status = ntps_pkg::STAT_MISS;
                end
            end
            ntps_pkg::CMD_LOOKUP: begin
                if (hit >= 0) res.found = 1'b1;
                else res.status = ntps_pkg::STAT_MISS;
            end
            ntps_pkg::CMD_SELECT: begin
                if (nbr_used == 0) begin
                    res.hop = ntps_pkg::HOP_MAX;
                end else begin
                    best = 0;
                    // later entry must strictly beat the current best
                    for (int i = 1; i < nbr_used; i++) begin
                        ra = nbr_rssi[i];
                        rb = nbr_rssi[best];
                        diff = (ra > rb) ? ra - rb : rb - ra;
                        if (ra != 0 && rb != 0 && diff > int'(margin_sh))
                            wins = ra > rb;
                        else
                            wins = nbr_count[i] < nbr_count[best];
                        if (wins) best = i;
                    end
                    res.parent_valid = 1'b1;
                    res.parent_mac   = nbr_mac[best];
                    res.parent_rssi  = nbr_rssi[best];
                    res.hop = (nbr_count[best] == ntps_pkg::HOP_MAX) ? ntps_pkg::HOP_MAX
                                                                     : nbr_count[best] + 8'd1;
                end
            end
            ntps_pkg::CMD_CLEAR: nbr_used = 0;
            default: ;
        endcase
        res.entry_count = nbr_used[ntps_pkg::ECNT_W-1:0];
        return res;
    endfunction

    task automatic push_cmd(logic [ntps_pkg::CMD_W-1:0] c, logic [ntps_pkg::MAC_W-1:0] m,
                            logic signed [ntps_pkg::RSSI_W-1:0] r,
                            logic [ntps_pkg::CNT_W-1:0] k);
        t_cmd_item it;
        it.cmd = c;
        it.mac = m;
        it.rssi = r;
        it.count = k;
        it.drain_first = 1'b0;
        pending_cmds = {pending_cmds, it};
    endtask

    // Random command; upd_pct steers how full the table runs.
    task automatic push_random(int upd_pct);
        int pick;
        int unsigned u;
        logic [ntps_pkg::CMD_W-1:0] c;
        logic [ntps_pkg::MAC_W-1:0] m;
        logic signed [ntps_pkg::RSSI_W-1:0] r;
        logic [ntps_pkg::CNT_W-1:0] k;
        pick = $urandom_range(99);
        u = $urandom_range(CMD_SPARE_HI, CMD_SPARE_LO);
        if (pick < upd_pct)                 c = ntps_pkg::CMD_UPDATE;
        else if (pick < upd_pct + 16)       c = ntps_pkg::CMD_DELETE;
        else if (pick < upd_pct + 30)       c = ntps_pkg::CMD_LOOKUP;
        else if (pick < 96)                 c = ntps_pkg::CMD_SELECT;
        else if (pick < 98)                 c = ntps_pkg::CMD_CLEAR;
        else                                c = u[ntps_pkg::CMD_W-1:0];
        if ($urandom_range(99) < 85) m = mac_pool[$urandom_range(POOL_SZ - 1)];
        else m = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(99);
        if (pick < 20) begin
            r = '0;
        end else if (pick < 30) begin
            r = $urandom_range(1) ? 9'sh0ff : 9'sh100;
        end else if (pick < 60) begin
            u = $urandom_range(40) - 20;                                 // close calls
            r = u[ntps_pkg::RSSI_W-1:0];
        end else begin
            u = $urandom;
            r = u[ntps_pkg::RSSI_W-1:0];
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            k = '0;
        end else if (pick < 20) begin
            k = ntps_pkg::HOP_MAX;
        end else if (pick < 60) begin
            u = $urandom_range(6);                                       // frequent ties
            k = u[ntps_pkg::CNT_W-1:0];
        end else begin
            u = $urandom;
            k = u[ntps_pkg::CNT_W-1:0];
        end
        push_cmd(c, m, r, k);
    endtask

    // All items sent and answered, input valid low.
    task automatic drain;
        while (pending_cmds.size() != 0 || cmd_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_margin(logic [8:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        margin_sh = v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(int n_items, int upd_pct);
        repeat (n_items) push_random(upd_pct);
    endtask

    // Sender: holds an item until accepted, idles at random otherwise.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!(cmd_ch.valid && !cmd_taken)) begin
            cmd_taken = 1'b0;
            if (pending_cmds.size() == 0 || (!no_idle && $urandom_range(99) < 37) ||
                (pending_cmds[0].drain_first && due_results.size() != 0)) begin
                cmd_ch.valid <= 1'b0;
            end else begin
                cmd_ch.cmd   <= pending_cmds[0].cmd;
                cmd_ch.mac   <= pending_cmds[0].mac;
                cmd_ch.rssi  <= pending_cmds[0].rssi;
                cmd_ch.count <= pending_cmds[0].count;
                cmd_ch.valid <= 1'b1;
                void'(pending_cmds.pop_front());
            end
        end
    end

    // Receiver: random ready, or a long counted hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= no_idle || $urandom_range(99) >= 37;
        end
    end

    // Accepted commands feed the shadow table; results are checked in order.
    always @(posedge i_clk) begin
        t_nbr_result got;
        t_nbr_result want;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                want = table_apply(cmd_ch.cmd, cmd_ch.mac, cmd_ch.rssi, cmd_ch.count);
                due_results = {due_results, want};
                cmd_taken = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.status       = res_ch.status;
                got.found        = res_ch.found;
                got.entry_count  = res_ch.entry_count;
                got.parent_valid = res_ch.parent_valid;
                got.parent_mac   = res_ch.parent_mac;
                got.parent_rssi  = res_ch.parent_rssi;
                got.hop          = res_ch.hop;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result with nothing outstanding: st=%0d n=%0d",
                                 got.status, got.entry_count);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("tb: mismatch at %0t", $realtime);
                            $display("  exp st=%0d fnd=%0d n=%0d pv=%0d mac=%h rssi=%0d hop=%0d",
                                     want.status, want.found, want.entry_count,
                                     want.parent_valid, want.parent_mac, want.parent_rssi,
                                     want.hop);
                            $display("  got st=%0d fnd=%0d n=%0d pv=%0d mac=%h rssi=%0d hop=%0d",
                                     got.status, got.found, got.entry_count,
                                     got.parent_valid, got.parent_mac, got.parent_rssi,
                                     got.hop);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_cmd_item mark;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = ntps_pkg::CMD_LOOKUP;
        cmd_ch.mac   = '0;
        cmd_ch.rssi  = '0;
        cmd_ch.count = '0;
        res_ch.ready = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        cmd_taken    = 1'b0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        nbr_used     = 0;
        margin_sh    = ntps_pkg::MARGIN_RST;
        mac_pool[0]  = '0;
        mac_pool[1]  = '1;
        for (int i = 2; i < POOL_SZ; i++)
            mac_pool[i] = {16'($urandom), 32'($urandom)};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table select, misses, field extremes, in-place
        // rewrite, delete with shift, saturating hop, unused codes, clear.
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_LOOKUP, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_DELETE, '1, '0, '0);
        push_cmd(ntps_pkg::CMD_UPDATE, '0, 9'sh100, 8'd0);
        push_cmd(ntps_pkg::CMD_UPDATE, '1, 9'sh0ff, ntps_pkg::HOP_MAX);
        push_cmd(ntps_pkg::CMD_UPDATE, mac_pool[2], '0, 8'd7);
        push_cmd(ntps_pkg::CMD_UPDATE, mac_pool[3], '0, 8'd3);
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_UPDATE, '0, 9'sd100, 8'd254);
        push_cmd(ntps_pkg::CMD_LOOKUP, '1, '0, '0);
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_DELETE, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_UPDATE, mac_pool[3], -9'sd1, ntps_pkg::HOP_MAX);
        push_cmd(ntps_pkg::CMD_UPDATE, mac_pool[2], '0, ntps_pkg::HOP_MAX);
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);      // tie on count, saturated hop
        push_cmd(CMD_SPARE_LO, mac_pool[2], '0, '0);
        push_cmd(CMD_SPARE_MID, '1, 9'sh0ff, ntps_pkg::HOP_MAX);
        push_cmd(CMD_SPARE_HI, '0, 9'sh100, '0);
        push_cmd(ntps_pkg::CMD_LOOKUP, mac_pool[2], '0, '0);
        push_cmd(ntps_pkg::CMD_CLEAR, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_SELECT, '0, '0, '0);
        push_cmd(ntps_pkg::CMD_LOOKUP, '1, '0, '0);

        // Random phases over several margins; extremes first.
        write_margin(9'd0);
        run_phase(250, 50);

        write_margin(9'd511);            // strength never decides
        run_phase(200, 55);

        // Back-to-back with a long result hold-off: the block backs up.
        write_margin(9'($urandom_range(1, 510)));
        no_idle = 1'b1;
        hold_req = 1'b1;
        run_phase(300, 45);
        drain();
        no_idle = 1'b0;

        write_margin(9'd5);
        run_phase(250, 60);

        // Sender stops mid-phase until every result is back.
        write_margin(ntps_pkg::MARGIN_RST);
        run_phase(120, 45);
        push_random(45);
        mark = pending_cmds[$];
        mark.drain_first = 1'b1;
        pending_cmds[$] = mark;
        run_phase(130, 45);

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
